### design/assert_macros.svh
// Assertion helpers for the design files; the top-level engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst, cond, expr, msg)
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg)

`endif

`endif

### design/bprf_pkg.sv
package bprf_pkg;

   typedef enum logic [1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_WORD     = 2'd2,
      STATUS_IDLE     = 2'd3
   } status_type;

   // Classification of an accepted request, carried from front to back.
   typedef enum logic [1:0] {
      KIND_START  = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_STEP   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_PLANE_BASE   = 2'd0,
      CSR_PLANE_STRIDE = 2'd1,
      CSR_PLANE_COUNT  = 2'd2,
      CSR_LINE_BYTES   = 2'd3
   } csr_index_type;

   localparam logic ACTION_START = 1'b0;

   localparam int unsigned CSR_DATA_BITS   = 24;
   localparam int unsigned BASE_BITS       = 24;
   localparam int unsigned COUNT_BITS      = 4;
   localparam int unsigned LINE_BYTES_BITS = 8;
   localparam int unsigned PEN_BITS        = 8;
   localparam int unsigned PLANE_IDX_BITS  = 3;
   localparam int unsigned WORD_BITS       = 16;
   localparam int unsigned OUT_ADDR_BITS   = 24;
   localparam int unsigned X_IN_BITS       = 10;
   localparam int unsigned XR_IN_BITS      = 11;

   localparam logic [BASE_BITS-1:0]       PLANE_BASE_RESET   = 24'd0;
   localparam logic [BASE_BITS-1:0]       PLANE_STRIDE_RESET = 24'd16000;
   localparam logic [COUNT_BITS-1:0]      PLANE_COUNT_RESET  = 4'd4;
   localparam logic [LINE_BYTES_BITS-1:0] LINE_BYTES_RESET   = 8'd80;

   localparam logic [WORD_BITS-1:0] MASK_FULL = 16'hffff;
   localparam logic [WORD_BITS-1:0] GRAY_EVEN = 16'haaaa;
   localparam logic [WORD_BITS-1:0] GRAY_ODD  = 16'h5555;
   localparam logic [3:0]           PIXEL_IN_WORD = 4'hf;

   typedef struct packed {
      status_type                 status;
      logic [OUT_ADDR_BITS-1:0]   address;
      logic [WORD_BITS-1:0]       write_bits;
      logic [WORD_BITS-1:0]       bit_mask;
      logic                       last;
   } rsp_type;

endpackage

### design/bprf_queue.sv
module bprf_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    store_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### design/bprf_front.sv
module bprf_front #(
   parameter int unsigned COORD_BITS = 10,
   parameter int unsigned ADDR_BITS  = 24,
   parameter int unsigned CMD_BITS   = 94
) (
   input  logic                                       req_push,
   output logic                                       req_full,
   input  logic                                       req_action,
   input  logic [bprf_pkg::X_IN_BITS-1:0]             req_x_left,
   input  logic [bprf_pkg::X_IN_BITS-1:0]             req_y_top,
   input  logic [bprf_pkg::XR_IN_BITS-1:0]            req_x_right,
   input  logic [bprf_pkg::X_IN_BITS-1:0]             req_y_bottom,
   input  logic [bprf_pkg::PEN_BITS-1:0]              req_pen,
   input  logic                                       req_dither,
   input  logic [bprf_pkg::BASE_BITS-1:0]             plane_base,
   input  logic [bprf_pkg::LINE_BYTES_BITS-1:0]       line_bytes,
   input  logic                                       queue_full,
   output logic                                       queue_push,
   output logic [CMD_BITS-1:0]                        queue_data
);

   localparam int unsigned XW   = COORD_BITS + 1;
   localparam int unsigned WW   = COORD_BITS - 3;
   localparam int unsigned WIDE = (XW > bprf_pkg::XR_IN_BITS) ? XW : bprf_pkg::XR_IN_BITS;
   localparam int unsigned PW   = COORD_BITS + bprf_pkg::LINE_BYTES_BITS;

   typedef struct packed {
      bprf_pkg::kind_type                    kind;
      logic [WW-1:0]                         word_count;
      logic [COORD_BITS-1:0]                 line_count;
      logic [bprf_pkg::WORD_BITS-1:0]        lead_edge;
      logic [bprf_pkg::WORD_BITS-1:0]        trail_edge;
      logic [bprf_pkg::PEN_BITS-1:0]         pen;
      logic                                  dither;
      logic [ADDR_BITS-1:0]                  origin;
   } cmd_type;

   cmd_type               cmd;
   logic [COORD_BITS-1:0] xl, yt, yb;
   logic [WIDE-1:0]       xr_wide, xr_limit;
   logic [XW-1:0]         xr, xr_up;
   logic [PW-1:0]         row_offset;
   logic [4:0]            right_shift;

   assign req_full   = queue_full;
   assign queue_push = req_push && !queue_full;
   assign queue_data = cmd;

   // Coordinates keep their low bits; the right edge saturates at the screen width.
   assign xl       = COORD_BITS'(req_x_left);
   assign yt       = COORD_BITS'(req_y_top);
   assign yb       = COORD_BITS'(req_y_bottom);
   assign xr_wide  = WIDE'(req_x_right);
   assign xr_limit = WIDE'(1 << COORD_BITS);
   assign xr       = XW'((xr_wide > xr_limit) ? xr_limit : xr_wide);
   assign xr_up    = xr + XW'(15);

   assign row_offset  = {{bprf_pkg::LINE_BYTES_BITS{1'b0}}, yt}
                        * {{COORD_BITS{1'b0}}, line_bytes};
   assign right_shift = 5'd16 - {1'b0, xr[3:0]};

   always_comb begin
      cmd.word_count = xr_up[XW-1:4] - WW'(xl[COORD_BITS-1:4]);
      cmd.line_count = yb - yt;
      cmd.lead_edge  = bprf_pkg::MASK_FULL >> (xl[3:0] & bprf_pkg::PIXEL_IN_WORD);
      cmd.trail_edge = (xr[3:0] == 4'd0) ? bprf_pkg::MASK_FULL
                                         : bprf_pkg::MASK_FULL << right_shift;
      cmd.pen        = req_pen;
      cmd.dither     = req_dither;
      cmd.origin     = ADDR_BITS'(plane_base) + ADDR_BITS'(row_offset)
                       + ADDR_BITS'({xl[COORD_BITS-1:4], 1'b0});
      priority if (req_action != bprf_pkg::ACTION_START) begin
         cmd.kind = bprf_pkg::KIND_STEP;
      end else if (({1'b0, xl} >= xr) || (yb < yt)) begin
         cmd.kind = bprf_pkg::KIND_REJECT;
      end else begin
         cmd.kind = bprf_pkg::KIND_START;
      end
   end

endmodule

### design/bprf_back.sv
module bprf_back #(
   parameter int unsigned MAX_PLANES = 8,
   parameter int unsigned COORD_BITS = 10,
   parameter int unsigned ADDR_BITS  = 24,
   parameter int unsigned CMD_BITS   = 94
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_empty,
   input  logic [CMD_BITS-1:0]                  cmd_data,
   output logic                                 cmd_pop,
   input  logic                                 rsp_full,
   output logic                                 rsp_push,
   output bprf_pkg::rsp_type                    rsp_data,
   input  logic [bprf_pkg::BASE_BITS-1:0]       plane_stride,
   input  logic [bprf_pkg::COUNT_BITS-1:0]      plane_count,
   input  logic [bprf_pkg::LINE_BYTES_BITS-1:0] line_bytes
);

   localparam int unsigned WW = COORD_BITS - 3;
   localparam int unsigned CB = bprf_pkg::COUNT_BITS;
   localparam int unsigned IB = bprf_pkg::PLANE_IDX_BITS;
   localparam int unsigned SB = bprf_pkg::BASE_BITS;

   typedef struct packed {
      bprf_pkg::kind_type                    kind;
      logic [WW-1:0]                         word_count;
      logic [COORD_BITS-1:0]                 line_count;
      logic [bprf_pkg::WORD_BITS-1:0]        lead_edge;
      logic [bprf_pkg::WORD_BITS-1:0]        trail_edge;
      logic [bprf_pkg::PEN_BITS-1:0]         pen;
      logic                                  dither;
      logic [ADDR_BITS-1:0]                  origin;
   } cmd_type;

   cmd_type cmd;

   logic                           busy_ff, busy_in;
   logic [IB-1:0]                  plane_index_ff, plane_index_in;
   logic [COORD_BITS-1:0]          line_index_ff, line_index_in;
   logic [WW-1:0]                  word_index_ff, word_index_in;
   logic [WW-1:0]                  word_count_ff, word_count_in;
   logic [COORD_BITS-1:0]          line_count_ff, line_count_in;
   logic [bprf_pkg::WORD_BITS-1:0] lead_edge_ff, lead_edge_in;
   logic [bprf_pkg::WORD_BITS-1:0] trail_edge_ff, trail_edge_in;
   logic [bprf_pkg::PEN_BITS-1:0]  pen_ff, pen_in;
   logic                           dither_ff, dither_in;
   logic [ADDR_BITS-1:0]           row_addr_ff, row_addr_in;
   logic [ADDR_BITS-1:0]           plane_addr_ff, plane_addr_in;

   logic                           fire;
   logic                           last_word, last_line, last_plane;
   logic [CB-1:0]                  planes_used;
   logic [bprf_pkg::WORD_BITS-1:0] word_mask;
   logic [CB+SB-1:0]               plane_offset;
   logic [ADDR_BITS-1:0]           word_addr, next_plane_addr;

   assign cmd      = cmd_data;
   assign fire     = !cmd_empty && !rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   assign planes_used = (plane_count == '0) ? CB'(1)
                      : (plane_count > CB'(MAX_PLANES)) ? CB'(MAX_PLANES) : plane_count;

   assign last_word  = ({1'b0, word_index_ff} + 1'b1) >= {1'b0, word_count_ff};
   assign last_line  = line_index_ff >= line_count_ff;
   assign last_plane = (CB'(plane_index_ff) + 1'b1) >= planes_used;

   assign word_addr       = row_addr_ff + ADDR_BITS'({word_index_ff, 1'b0});
   // The next plane starts at the rectangle's first word plus its index times
   // the stride as it stands now, so a stride written mid-fill takes effect.
   assign plane_offset    = {{SB{1'b0}}, CB'(plane_index_ff) + CB'(1)}
                            * {{CB{1'b0}}, plane_stride};
   assign next_plane_addr = plane_addr_ff + ADDR_BITS'(plane_offset);

   always_comb begin
      word_mask = bprf_pkg::MASK_FULL;
      if (word_index_ff == '0) begin
         word_mask = word_mask & lead_edge_ff;
      end
      if (last_word) begin
         word_mask = word_mask & trail_edge_ff;
      end
      if (dither_ff) begin
         word_mask = word_mask & (line_index_ff[0] ? bprf_pkg::GRAY_ODD : bprf_pkg::GRAY_EVEN);
      end
   end

   always_comb begin
      busy_in        = busy_ff;
      plane_index_in = plane_index_ff;
      line_index_in  = line_index_ff;
      word_index_in  = word_index_ff;
      word_count_in  = word_count_ff;
      line_count_in  = line_count_ff;
      lead_edge_in   = lead_edge_ff;
      trail_edge_in  = trail_edge_ff;
      pen_in         = pen_ff;
      dither_in      = dither_ff;
      row_addr_in    = row_addr_ff;
      plane_addr_in  = plane_addr_ff;
      rsp_data       = '0;

      if (fire) begin
         unique case (cmd.kind)
            bprf_pkg::KIND_START: begin
               rsp_data.status = bprf_pkg::STATUS_ACCEPTED;
               busy_in        = 1'b1;
               plane_index_in = '0;
               line_index_in  = '0;
               word_index_in  = '0;
               word_count_in  = cmd.word_count;
               line_count_in  = cmd.line_count;
               lead_edge_in   = cmd.lead_edge;
               trail_edge_in  = cmd.trail_edge;
               pen_in         = cmd.pen;
               dither_in      = cmd.dither;
               row_addr_in    = cmd.origin;
               plane_addr_in  = cmd.origin;
            end
            bprf_pkg::KIND_REJECT: begin
               rsp_data.status = bprf_pkg::STATUS_REJECTED;
               busy_in         = 1'b0;
            end
            bprf_pkg::KIND_STEP: begin
               if (!busy_ff) begin
                  rsp_data.status = bprf_pkg::STATUS_IDLE;
               end else begin
                  rsp_data.status     = bprf_pkg::STATUS_WORD;
                  rsp_data.address    = bprf_pkg::OUT_ADDR_BITS'(word_addr);
                  rsp_data.write_bits = pen_ff[plane_index_ff] ? bprf_pkg::MASK_FULL : '0;
                  rsp_data.bit_mask   = word_mask;
                  priority if (!last_word) begin
                     word_index_in = word_index_ff + 1'b1;
                  end else if (!last_line) begin
                     word_index_in = '0;
                     line_index_in = line_index_ff + 1'b1;
                     row_addr_in   = row_addr_ff + ADDR_BITS'(line_bytes);
                  end else if (!last_plane) begin
                     word_index_in  = '0;
                     line_index_in  = '0;
                     plane_index_in = plane_index_ff + 1'b1;
                     row_addr_in    = next_plane_addr;
                  end else begin
                     rsp_data.last  = 1'b1;
                     busy_in        = 1'b0;
                     word_index_in  = '0;
                     line_index_in  = '0;
                     plane_index_in = '0;
                  end
               end
            end
            default: begin
               rsp_data.status = bprf_pkg::STATUS_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         plane_index_ff <= '0;
         line_index_ff  <= '0;
         word_index_ff  <= '0;
      end else begin
         busy_ff        <= busy_in;
         plane_index_ff <= plane_index_in;
         line_index_ff  <= line_index_in;
         word_index_ff  <= word_index_in;
      end
   end

   always_ff @(posedge clock) begin
      word_count_ff <= word_count_in;
      line_count_ff <= line_count_in;
      lead_edge_ff  <= lead_edge_in;
      trail_edge_ff <= trail_edge_in;
      pen_ff        <= pen_in;
      dither_ff     <= dither_in;
      row_addr_ff   <= row_addr_in;
      plane_addr_ff <= plane_addr_in;
   end

endmodule

### design/bitplane_rect_fill_engine.sv
// Rectangle fill engine for a planar frame buffer.
// Requests enter through a queue-style port: a beat is taken when req_push
// is high and req_full is low. A start request latches a rectangle, pen and
// fill pattern; every step request during a fill yields one 16-bit word
// operation (address, write bits, bit mask), plane by plane, line by line,
// left to right. Every request gives exactly one result, in order.
// Results leave through a queue-style port: the oldest result is shown while
// rsp_empty is low and is taken when rsp_pop is high.
// The csr_ port writes plane base, plane stride, plane count and line bytes;
// it is to be written only while no request is in flight; the block itself
// does not enforce this. The front classifies a request and works out the
// start address with one multiply in the cycle of the beat and writes the
// command queue; the back then takes the command, steps the fill counters
// and writes the output queue, from which the result reaches the rsp_ ports.
// Throughput is one request per cycle while the receiver keeps up, set by the
// back's counter update. Two-entry queues sit between front and back and on
// the output, so a stalled receiver fills the output queue, then the command
// queue, and only then raises req_full. Reset empties both queues, leaves the
// engine idle and returns the csr_ registers to their reset values.
`include "assert_macros.svh"

module bitplane_rect_fill_engine #(
   parameter int unsigned MAX_PLANES = 8,
   parameter int unsigned COORD_BITS = 10,
   parameter int unsigned ADDR_BITS  = 24
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic                                     req_action,
   input  logic [bprf_pkg::X_IN_BITS-1:0]           req_x_left,
   input  logic [bprf_pkg::X_IN_BITS-1:0]           req_y_top,
   input  logic [bprf_pkg::XR_IN_BITS-1:0]          req_x_right,
   input  logic [bprf_pkg::X_IN_BITS-1:0]           req_y_bottom,
   input  logic [bprf_pkg::PEN_BITS-1:0]            req_pen,
   input  logic                                     req_dither,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic [1:0]                               rsp_status,
   output logic [bprf_pkg::OUT_ADDR_BITS-1:0]       rsp_address,
   output logic [bprf_pkg::WORD_BITS-1:0]           rsp_write_bits,
   output logic [bprf_pkg::WORD_BITS-1:0]           rsp_bit_mask,
   output logic                                     rsp_last,
   input  logic                                     csr_we,
   input  logic [1:0]                               csr_index,
   input  logic [bprf_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   localparam int unsigned CMD_BITS = 2 + (COORD_BITS - 3) + COORD_BITS
                                    + 2 * bprf_pkg::WORD_BITS + bprf_pkg::PEN_BITS + 1
                                    + ADDR_BITS;
   localparam int unsigned RSP_BITS = $bits(bprf_pkg::rsp_type);

   logic [bprf_pkg::BASE_BITS-1:0]       plane_base_ff;
   logic [bprf_pkg::BASE_BITS-1:0]       plane_stride_ff;
   logic [bprf_pkg::COUNT_BITS-1:0]      plane_count_ff;
   logic [bprf_pkg::LINE_BYTES_BITS-1:0] line_bytes_ff;

   logic                  cmd_q_push, cmd_q_full, cmd_q_pop, cmd_q_empty;
   logic [CMD_BITS-1:0]   cmd_q_wr_data, cmd_q_rd_data;
   logic                  rsp_q_push, rsp_q_full;
   bprf_pkg::rsp_type     rsp_q_wr_data, rsp_head;
   logic [RSP_BITS-1:0]   rsp_q_rd_data;
   logic                  head_valid, head_is_word, head_clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_base_ff   <= bprf_pkg::PLANE_BASE_RESET;
         plane_stride_ff <= bprf_pkg::PLANE_STRIDE_RESET;
         plane_count_ff  <= bprf_pkg::PLANE_COUNT_RESET;
         line_bytes_ff   <= bprf_pkg::LINE_BYTES_RESET;
      end else if (csr_we) begin
         unique case (bprf_pkg::csr_index_type'(csr_index))
            bprf_pkg::CSR_PLANE_BASE:   plane_base_ff   <= csr_wdata;
            bprf_pkg::CSR_PLANE_STRIDE: plane_stride_ff <= csr_wdata;
            bprf_pkg::CSR_PLANE_COUNT:  plane_count_ff  <= bprf_pkg::COUNT_BITS'(csr_wdata);
            bprf_pkg::CSR_LINE_BYTES:   line_bytes_ff   <= bprf_pkg::LINE_BYTES_BITS'(csr_wdata);
            default: ;
         endcase
      end
   end

   bprf_front #(
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_front (
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_x_left   (req_x_left),
      .req_y_top    (req_y_top),
      .req_x_right  (req_x_right),
      .req_y_bottom (req_y_bottom),
      .req_pen      (req_pen),
      .req_dither   (req_dither),
      .plane_base   (plane_base_ff),
      .line_bytes   (line_bytes_ff),
      .queue_full   (cmd_q_full),
      .queue_push   (cmd_q_push),
      .queue_data   (cmd_q_wr_data)
   );

   bprf_queue #(
      .WIDTH (CMD_BITS),
      .DEPTH (2)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_q_push),
      .wr_data (cmd_q_wr_data),
      .full    (cmd_q_full),
      .pop     (cmd_q_pop),
      .rd_data (cmd_q_rd_data),
      .empty   (cmd_q_empty)
   );

   bprf_back #(
      .MAX_PLANES (MAX_PLANES),
      .COORD_BITS (COORD_BITS),
      .ADDR_BITS  (ADDR_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_q_empty),
      .cmd_data     (cmd_q_rd_data),
      .cmd_pop      (cmd_q_pop),
      .rsp_full     (rsp_q_full),
      .rsp_push     (rsp_q_push),
      .rsp_data     (rsp_q_wr_data),
      .plane_stride (plane_stride_ff),
      .plane_count  (plane_count_ff),
      .line_bytes   (line_bytes_ff)
   );

   bprf_queue #(
      .WIDTH (RSP_BITS),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_q_push),
      .wr_data (rsp_q_wr_data),
      .full    (rsp_q_full),
      .pop     (rsp_pop),
      .rd_data (rsp_q_rd_data),
      .empty   (rsp_empty)
   );

   assign rsp_head       = rsp_q_rd_data;
   assign rsp_status     = rsp_head.status;
   assign rsp_address    = rsp_head.address;
   assign rsp_write_bits = rsp_head.write_bits;
   assign rsp_bit_mask   = rsp_head.bit_mask;
   assign rsp_last       = rsp_head.last;

   assign head_valid   = !rsp_empty;
   assign head_is_word = (rsp_status == bprf_pkg::STATUS_WORD);
   assign head_clear   = (rsp_bit_mask == '0) && (rsp_address == '0)
                         && (rsp_write_bits == '0);

   // Each command the back consumes must find room in the output queue.
   `ASSERT_IMPLY(a_rsp_no_overflow, clock, reset, rsp_q_push, !rsp_q_full, "result beat lost")
   `ASSERT_NEXT(a_result_follows, clock, reset, cmd_q_pop, !rsp_empty, "no result after command")
   `ASSERT_IMPLY(a_last_is_word, clock, reset, head_valid && rsp_last, head_is_word, "stray last")
   `ASSERT_IMPLY(a_plain_status_clear, clock, reset, head_valid && !head_is_word, head_clear, "payload")

endmodule

### tb/bprf_fill_checker.sv
`timescale 1ns / 100ps

module bprf_fill_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  logic                                 req_action,
   input  logic [bprf_pkg::X_IN_BITS-1:0]       req_x_left,
   input  logic [bprf_pkg::X_IN_BITS-1:0]       req_y_top,
   input  logic [bprf_pkg::XR_IN_BITS-1:0]      req_x_right,
   input  logic [bprf_pkg::X_IN_BITS-1:0]       req_y_bottom,
   input  logic [bprf_pkg::PEN_BITS-1:0]        req_pen,
   input  logic                                 req_dither,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  logic [1:0]                           rsp_status,
   input  logic [bprf_pkg::OUT_ADDR_BITS-1:0]   rsp_address,
   input  logic [bprf_pkg::WORD_BITS-1:0]       rsp_write_bits,
   input  logic [bprf_pkg::WORD_BITS-1:0]       rsp_bit_mask,
   input  logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [bprf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output int                                   pending,
   output int                                   fail_count
);

   import bprf_pkg::*;

   // Shadow copies of the register file.
   logic [BASE_BITS-1:0]       base_reg;
   logic [BASE_BITS-1:0]       stride_reg;
   logic [COUNT_BITS-1:0]      count_reg;
   logic [LINE_BYTES_BITS-1:0] line_bytes_reg;

   // Fill walk state.
   bit                         filling;
   int unsigned                plane_at;
   int unsigned                line_at;
   int unsigned                word_at;
   int unsigned                words_per_line;
   int unsigned                lines_less_one;
   logic [WORD_BITS-1:0]       left_edge;
   logic [WORD_BITS-1:0]       right_edge;
   logic [PEN_BITS-1:0]        pen_held;
   bit                         gray_held;
   logic [OUT_ADDR_BITS-1:0]   line_addr;
   logic [OUT_ADDR_BITS-1:0]   origin_addr;

   rsp_type expected_ops[$];

   initial fail_count = 0;
   initial pending = 0;

   function automatic rsp_type predict_fill(
      input logic                   action,
      input logic [X_IN_BITS-1:0]   x_left,
      input logic [X_IN_BITS-1:0]   y_top,
      input logic [XR_IN_BITS-1:0]  x_right,
      input logic [X_IN_BITS-1:0]   y_bottom,
      input logic [PEN_BITS-1:0]    pen,
      input logic                   dither
   );
      rsp_type              res;
      logic [XR_IN_BITS-1:0] xr;
      logic [31:0]          sum;
      logic [WORD_BITS-1:0] mask;
      int unsigned          planes;
      bit                   last_word;

      res = '0;
      if (action == ACTION_START) begin
         xr = (x_right > 11'd1024) ? 11'd1024 : x_right;
         filling = 1'b0;
         if (xr <= {1'b0, x_left} || y_bottom < y_top) begin
            res.status = STATUS_REJECTED;
            return res;
         end
         words_per_line = ((int'(xr) + 15) >> 4) - (int'(x_left) >> 4);
         lines_less_one = {22'h0, y_bottom - y_top};
         left_edge = MASK_FULL >> x_left[3:0];
         right_edge = (xr[3:0] == 4'd0) ? MASK_FULL : ~(MASK_FULL >> xr[3:0]);
         pen_held = pen;
         gray_held = dither;
         sum = {8'h0, base_reg} + {22'h0, y_top} * {24'h0, line_bytes_reg}
               + {25'h0, x_left[X_IN_BITS-1:4], 1'b0};
         origin_addr = sum[OUT_ADDR_BITS-1:0];
         line_addr = origin_addr;
         plane_at = 0;
         line_at = 0;
         word_at = 0;
         filling = 1'b1;
         res.status = STATUS_ACCEPTED;
         return res;
      end

      if (!filling) begin
         res.status = STATUS_IDLE;
         return res;
      end

      mask = MASK_FULL;
      if (word_at == 0) mask &= left_edge;
      last_word = (word_at + 1 >= words_per_line);
      if (last_word) mask &= right_edge;
      if (gray_held) mask &= line_at[0] ? GRAY_ODD : GRAY_EVEN;

      sum = {8'h0, line_addr} + (word_at << 1);
      res.status = STATUS_WORD;
      res.address = sum[OUT_ADDR_BITS-1:0];
      res.write_bits = pen_held[plane_at[2:0]] ? MASK_FULL : '0;
      res.bit_mask = mask;

      // A plane count of zero still writes one plane; anything above eight is capped.
      planes = (count_reg == 0) ? 1 : (count_reg > 8) ? 8 : count_reg;

      if (!last_word) begin
         word_at++;
      end else if (line_at < lines_less_one) begin
         word_at = 0;
         line_at++;
         sum = {8'h0, line_addr} + {24'h0, line_bytes_reg};
         line_addr = sum[OUT_ADDR_BITS-1:0];
      end else if (plane_at + 1 < planes) begin
         word_at = 0;
         line_at = 0;
         plane_at++;
         sum = {8'h0, origin_addr} + plane_at * {8'h0, stride_reg};
         line_addr = sum[OUT_ADDR_BITS-1:0];
      end else begin
         res.last = 1'b1;
         filling = 1'b0;
         word_at = 0;
         line_at = 0;
         plane_at = 0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         base_reg = PLANE_BASE_RESET;
         stride_reg = PLANE_STRIDE_RESET;
         count_reg = PLANE_COUNT_RESET;
         line_bytes_reg = LINE_BYTES_RESET;
         filling = 1'b0;
         plane_at = 0;
         line_at = 0;
         word_at = 0;
         expected_ops.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PLANE_BASE:   base_reg = csr_wdata[BASE_BITS-1:0];
               CSR_PLANE_STRIDE: stride_reg = csr_wdata[BASE_BITS-1:0];
               CSR_PLANE_COUNT:  count_reg = csr_wdata[COUNT_BITS-1:0];
               CSR_LINE_BYTES:   line_bytes_reg = csr_wdata[LINE_BYTES_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_pop && !rsp_empty) begin
            if (expected_ops.size() == 0) begin
               $error("result beat with nothing outstanding, status %0d", rsp_status);
               fail_count++;
            end else begin
               want = expected_ops.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_address !== want.address) begin
                  $error("address: expected %h, got %h", want.address, rsp_address);
                  fail_count++;
               end
               if (rsp_write_bits !== want.write_bits) begin
                  $error("write_bits: expected %h, got %h", want.write_bits, rsp_write_bits);
                  fail_count++;
               end
               if (rsp_bit_mask !== want.bit_mask) begin
                  $error("bit_mask: expected %h, got %h", want.bit_mask, rsp_bit_mask);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end

         if (req_push && !req_full) begin
            expected_ops.push_back(predict_fill(req_action, req_x_left, req_y_top,
                                                req_x_right, req_y_bottom, req_pen,
                                                req_dither));
         end
         pending <= expected_ops.size();
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

   import bprf_pkg::*;

   localparam logic ACTION_STEP = ~ACTION_START;
   localparam int   HOLD_CYCLES = 80;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic                        req_action = ACTION_START;
   logic [X_IN_BITS-1:0]        req_x_left = '0;
   logic [X_IN_BITS-1:0]        req_y_top = '0;
   logic [XR_IN_BITS-1:0]       req_x_right = '0;
   logic [X_IN_BITS-1:0]        req_y_bottom = '0;
   logic [PEN_BITS-1:0]         req_pen = '0;
   logic                        req_dither = 1'b0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [1:0]                  rsp_status;
   logic [OUT_ADDR_BITS-1:0]    rsp_address;
   logic [WORD_BITS-1:0]        rsp_write_bits;
   logic [WORD_BITS-1:0]        rsp_bit_mask;
   logic                        rsp_last;
   logic                        csr_we = 1'b0;
   logic [1:0]                  csr_index = CSR_PLANE_BASE;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   int  pending;
   int  fail_count;
   int  send_idle = 16;
   int  recv_idle = 55;
   int  planes_active = 4;
   bit  hold_request = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bitplane_rect_fill_engine dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_action(req_action),
      .req_x_left(req_x_left), .req_y_top(req_y_top), .req_x_right(req_x_right),
      .req_y_bottom(req_y_bottom), .req_pen(req_pen), .req_dither(req_dither),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_address(rsp_address), .rsp_write_bits(rsp_write_bits),
      .rsp_bit_mask(rsp_bit_mask), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   bprf_fill_checker fill_monitor (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_action(req_action),
      .req_x_left(req_x_left), .req_y_top(req_y_top), .req_x_right(req_x_right),
      .req_y_bottom(req_y_bottom), .req_pen(req_pen), .req_dither(req_dither),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_status(rsp_status),
      .rsp_address(rsp_address), .rsp_write_bits(rsp_write_bits),
      .rsp_bit_mask(rsp_bit_mask), .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .pending(pending), .fail_count(fail_count)
   );

   // Offers one request beat and returns at the edge where it is taken.
   task automatic push_item(
      input logic                  action,
      input logic [X_IN_BITS-1:0]  x_left,
      input logic [X_IN_BITS-1:0]  y_top,
      input logic [XR_IN_BITS-1:0] x_right,
      input logic [X_IN_BITS-1:0]  y_bottom,
      input logic [PEN_BITS-1:0]   pen,
      input logic                  dither
   );
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_action <= action;
      req_x_left <= x_left;
      req_y_top <= y_top;
      req_x_right <= x_right;
      req_y_bottom <= y_bottom;
      req_pen <= pen;
      req_dither <= dither;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // A start with the given geometry and a random pen and pattern.
   task automatic push_start(input int xl, input int yt, input int xr, input int yb);
      push_item(ACTION_START, X_IN_BITS'(xl), X_IN_BITS'(yt), XR_IN_BITS'(xr),
                X_IN_BITS'(yb), PEN_BITS'($urandom), 1'($urandom));
   endtask

   task automatic push_step();
      push_item(ACTION_STEP, X_IN_BITS'($urandom), X_IN_BITS'($urandom),
                XR_IN_BITS'($urandom), X_IN_BITS'($urandom), PEN_BITS'($urandom),
                1'($urandom));
   endtask

   task automatic push_steps(input int count);
      repeat (count) push_step();
   endtask

   // Holds the sender back until every outstanding result has been taken.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(
      input logic [BASE_BITS-1:0]       base,
      input logic [BASE_BITS-1:0]       stride,
      input logic [COUNT_BITS-1:0]      count,
      input logic [LINE_BYTES_BITS-1:0] line_bytes
   );
      csr_we <= 1'b1;
      csr_index <= CSR_PLANE_BASE;
      csr_wdata <= base;
      @(posedge clock);
      csr_index <= CSR_PLANE_STRIDE;
      csr_wdata <= stride;
      @(posedge clock);
      csr_index <= CSR_PLANE_COUNT;
      csr_wdata <= CSR_DATA_BITS'(count);
      @(posedge clock);
      csr_index <= CSR_LINE_BYTES;
      csr_wdata <= CSR_DATA_BITS'(line_bytes);
      @(posedge clock);
      csr_we <= 1'b0;
      planes_active = (count == 0) ? 1 : (count > 8) ? 8 : int'(count);
   endtask

   // Mostly complete rectangles with random geometry, plus rejected starts,
   // steps on an idle engine and fills abandoned part way through.
   task automatic run_rectangles(input int budget);
      int sent, pick, xl, xr, yt, yb, xs, words, total, n;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(99);
         xl = $urandom_range(1023);
         yt = $urandom_range(1023);
         if (pick < 6) begin
            if ($urandom_range(1)) begin
               xr = $urandom_range(xl);
               yb = $urandom_range(1023, yt);
            end else begin
               yt = $urandom_range(1023, 1);
               xr = $urandom_range(2047, xl + 1);
               yb = $urandom_range(yt - 1);
            end
            push_start(xl, yt, xr, yb);
            push_step();
            sent += 2;
         end else if (pick < 10) begin
            push_start(xl, yt, $urandom_range(2047), $urandom_range(1023));
            n = $urandom_range(6);
            push_steps(n);
            sent += n + 1;
         end else begin
            xr = xl + (($urandom_range(9) == 0) ? $urandom_range(1024, 1)
                                                 : $urandom_range(40, 1));
            yb = yt + $urandom_range(2);
            if (yb > 1023) yb = 1023;
            xs = (xr > 1024) ? 1024 : xr;
            words = ((xs + 15) >> 4) - (xl >> 4);
            total = words * (yb - yt + 1) * planes_active;
            if (total > 48)
               n = $urandom_range(48, 1);
            else if ($urandom_range(99) < 85)
               n = total;
            else
               n = $urandom_range(total + 2);
            push_start(xl, yt, xr, yb);
            push_steps(n);
            sent += n + 1;
         end
      end
   endtask

   task automatic run_phase(
      input logic [BASE_BITS-1:0]       base,
      input logic [BASE_BITS-1:0]       stride,
      input logic [COUNT_BITS-1:0]      count,
      input logic [LINE_BYTES_BITS-1:0] line_bytes,
      input int                         budget
   );
      program_regs(base, stride, count, line_bytes);
      run_rectangles(budget);
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values (four planes).
      push_step();
      push_item(ACTION_START, 10'd5, 10'd0, 11'd5, 10'd0, 8'h00, 1'b0);
      push_item(ACTION_START, 10'd0, 10'd9, 11'd16, 10'd8, 8'hff, 1'b1);
      // Bottom right corner, right edge saturated, one gray word per plane.
      push_item(ACTION_START, 10'd1023, 10'd1023, 11'd2047, 10'd1023, 8'ha5, 1'b1);
      push_steps(4);
      // Both edges fall in one word on a checkerboard fill.
      push_item(ACTION_START, 10'd3, 10'd0, 11'd12, 10'd1, 8'h0f, 1'b1);
      push_steps(3);
      // A full-screen start abandons the fill in progress.
      push_item(ACTION_START, 10'd0, 10'd0, 11'd1024, 10'd1023, 8'hff, 1'b0);
      push_steps(2);
      push_item(ACTION_START, 10'd17, 10'd2, 11'd40, 10'd2, 8'h00, 1'b0);
      push_steps(9);
      wait_drained();

      run_phase(24'h000000, 24'h000000, 4'd1, 8'd2, 65);
      hold_request = 1'b1;
      run_phase(24'hffffff, 24'hffffff, 4'd8, 8'd128, 65);

      send_idle = 55;
      recv_idle = 16;
      program_regs(BASE_BITS'($urandom), BASE_BITS'($urandom), 4'd0,
                   LINE_BYTES_BITS'($urandom_range(128, 2)));
      run_rectangles(30);
      wait_drained();
      run_rectangles(35);
      wait_drained();
      run_phase(BASE_BITS'($urandom), BASE_BITS'($urandom), 4'd15,
                LINE_BYTES_BITS'($urandom_range(128, 2)), 65);

      send_idle = 0;
      recv_idle = 0;
      run_phase(BASE_BITS'($urandom), BASE_BITS'($urandom),
                COUNT_BITS'($urandom_range(8, 1)),
                LINE_BYTES_BITS'($urandom_range(128, 2)), 65);
      run_phase(BASE_BITS'($urandom), BASE_BITS'($urandom),
                COUNT_BITS'($urandom_range(3, 1)),
                LINE_BYTES_BITS'($urandom_range(128, 2)), 65);

      if (fail_count == 0 && pending == 0) begin
         $display("bitplane_rect_fill_engine test passed");
      end else begin
         $display("bitplane_rect_fill_engine test failed");
      end
      $finish;
   end

   // Result side: random pops, and one long hold-off so that the queues fill
   // and the request side stalls.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_pop <= ($urandom_range(99) >= recv_idle);
      end
   end

   initial begin
      #4000000;
      $display("bitplane_rect_fill_engine test failed");
      $finish;
   end

endmodule
